@@ src/octrip_pkg.sv @@
// ----------------------------------------------------------------------------
// octrip_pkg
// Types, constants and compare helpers for the three-phase overcurrent trip.
// ----------------------------------------------------------------------------
package octrip_pkg;

	localparam int COUNT_BITS_DEF = 17;
	localparam int LIMIT_W        = 17;
	localparam int CUR_W          = 18;
	localparam int CFG_IDX_W      = 3;
	localparam int S_TDATA_W      = 56;
	localparam int M_TDATA_W      = 8;

	localparam logic [LIMIT_W-1:0] INSTANT_LIMIT_RST = 17'd40000;
	localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST   = 17'd39000;
	localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST    = 17'd38000;
	localparam logic [LIMIT_W-1:0] SHORT_RUN_RST     = 17'd10;
	localparam logic [LIMIT_W-1:0] LONG_RUN_RST      = 17'd100000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INSTANT_LIMIT = 3'd0,
		REG_SHORT_LIMIT   = 3'd1,
		REG_LONG_LIMIT    = 3'd2,
		REG_SHORT_RUN     = 3'd3,
		REG_LONG_RUN      = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		TRIP_NONE    = 2'd0,
		TRIP_INSTANT = 2'd1,
		TRIP_SHORT   = 2'd2,
		TRIP_LONG    = 2'd3
	} trip_code_t;

	typedef logic [LIMIT_W-1:0]      limit_t;
	typedef logic signed [CUR_W-1:0] current_t;

	typedef struct packed {
		current_t w;
		current_t v;
		current_t u;
	} phases_t;

	typedef struct packed {
		limit_t instant_limit;
		limit_t short_limit;
		limit_t long_limit;
		limit_t short_run;
		limit_t long_run;
	} cfg_regs_t;

	function automatic logic phase_over(current_t x, limit_t lim);
		logic [CUR_W-1:0] mag;
		mag = x[CUR_W-1] ? $unsigned(-x) : $unsigned(x);
		return mag > {1'b0, lim};
	endfunction

	function automatic logic beyond(phases_t ph, limit_t lim);
		return phase_over(ph.u, lim) | phase_over(ph.v, lim) | phase_over(ph.w, lim);
	endfunction

endpackage

@@ src/octrip_cfg.sv @@
// ----------------------------------------------------------------------------
// octrip_cfg
// Limit and run-length registers, written through the config channel.
// ----------------------------------------------------------------------------
module octrip_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [octrip_pkg::CFG_IDX_W-1:0] cfg_index,
	input  octrip_pkg::limit_t              cfg_data,
	output octrip_pkg::cfg_regs_t           regs
);
	import octrip_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.instant_limit <= INSTANT_LIMIT_RST;
			regs_q.short_limit   <= SHORT_LIMIT_RST;
			regs_q.long_limit    <= LONG_LIMIT_RST;
			regs_q.short_run     <= SHORT_RUN_RST;
			regs_q.long_run      <= LONG_RUN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INSTANT_LIMIT: regs_q.instant_limit <= cfg_data;
				REG_SHORT_LIMIT:   regs_q.short_limit   <= cfg_data;
				REG_LONG_LIMIT:    regs_q.long_limit    <= cfg_data;
				REG_SHORT_RUN:     regs_q.short_run     <= cfg_data;
				REG_LONG_RUN:      regs_q.long_run      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

@@ src/octrip_level.sv @@
// ----------------------------------------------------------------------------
// octrip_level
// One timed level: over-limit check, saturating run counter, trip on reach.
// ----------------------------------------------------------------------------
module octrip_level #(
	parameter int COUNT_BITS = octrip_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  octrip_pkg::phases_t ph,
	input  octrip_pkg::limit_t  limit,
	input  octrip_pkg::limit_t  run,
	output logic                trip
);
	import octrip_pkg::*;

	localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  over;
	logic                  sat;

	assign over    = beyond(ph, limit);
	assign sat     = &cnt_q;
	assign cnt_inc = cnt_q + 1'b1;
	assign trip    = en && over && !sat && (CMP_W'(cnt_inc) == CMP_W'(run));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en) begin
			if (!over) begin
				cnt_q <= '0;
			end else if (!sat) begin
				cnt_q <= cnt_inc;
			end
		end
	end

endmodule

@@ src/three_phase_overcurrent_trip_top.sv @@
// ----------------------------------------------------------------------------
// three_phase_overcurrent_trip_top
// Instant, short and long overcurrent trips on three phase current samples.
//
//  channel  dir  request            accepted when
//  s_*      in   one current sample s_tvalid & s_tready
//  m_*      out  one trip status    m_tvalid & m_tready
//  cfg_*    in   register write     cfg_valid & cfg_ready (always ready)
//
// One sample per cycle sustained while the result is not stalled by m_tready.
// Input register, one pass of compares and counters, result register.
// Reset clears counters, alarm and code; registers take their defaults.
// A stalled result holds; the input register still takes one more sample.
// ----------------------------------------------------------------------------
module three_phase_overcurrent_trip_top #(
	parameter int COUNT_BITS = octrip_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// current_u, current_v, current_w, zero pad
	input  logic [octrip_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// alarm_latched, alarm_code, instant_over, zero pad
	output logic [octrip_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [octrip_pkg::CFG_IDX_W-1:0] cfg_index,
	input  octrip_pkg::limit_t               cfg_data
);
	import octrip_pkg::*;

	cfg_regs_t  regs;
	phases_t    ph_s1;
	logic       valid_s1;
	logic       valid_s2;
	logic       advance;
	logic       inst;
	logic       short_trip;
	logic       long_trip;
	logic       alarm_q;
	trip_code_t code_q;
	trip_code_t code_nxt;
	logic       alarm_s2;
	trip_code_t code_s2;
	logic       inst_s2;

	assign cfg_ready = 1'b1;

	octrip_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ph_s1.u <= s_tdata[CUR_W-1:0];
			ph_s1.v <= s_tdata[2*CUR_W-1:CUR_W];
			ph_s1.w <= s_tdata[3*CUR_W-1:2*CUR_W];
		end
	end

	assign inst = beyond(ph_s1, regs.instant_limit);

	octrip_level #(.COUNT_BITS(COUNT_BITS)) u_short (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.ph     (ph_s1),
		.limit  (regs.short_limit),
		.run    (regs.short_run),
		.trip   (short_trip)
	);

	octrip_level #(.COUNT_BITS(COUNT_BITS)) u_long (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.ph     (ph_s1),
		.limit  (regs.long_limit),
		.run    (regs.long_run),
		.trip   (long_trip)
	);

	// later level wins the code
	always_comb begin
		code_nxt = code_q;
		if (inst)       code_nxt = TRIP_INSTANT;
		if (short_trip) code_nxt = TRIP_SHORT;
		if (long_trip)  code_nxt = TRIP_LONG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q  <= 1'b0;
			code_q   <= TRIP_NONE;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				alarm_q <= alarm_q | inst | short_trip | long_trip;
				code_q  <= code_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			alarm_s2 <= alarm_q | inst | short_trip | long_trip;
			code_s2  <= code_nxt;
			inst_s2  <= inst;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_TDATA_W-4){1'b0}}, inst_s2, code_s2, alarm_s2};

endmodule
